/* hw/rtl/siim_pkg.sv */
`default_nettype none
// ============================================================================
// siim_pkg
// Shared types for the sorted interval table: cell operations, the state
// carried by one cell and the sequencer states.
// ============================================================================
package siim_pkg;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CMP,
        OP_LOAD,
        OP_PREV,
        OP_NEXT
    } t_cell_op;

    typedef struct packed {
        logic [31:0] s;
        logic [31:0] e;
        logic        b;
        logic        m;
    } t_cell_st;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD,
        ST_SHIFT
    } t_state;

endpackage
`default_nettype wire

/* hw/rtl/siim_cell.sv */
`default_nettype none
// ============================================================================
// siim_cell
// One table slot: holds one interval and its compare flags, and loads, keeps
// or takes the contents of a neighboring slot as the sequencer directs.
// ============================================================================
module siim_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire siim_pkg::t_cell_op i_op,
    input  wire logic               i_valid,
    input  wire logic [31:0]        i_lo,
    input  wire logic [31:0]        i_hi,
    input  wire siim_pkg::t_cell_st i_prev,
    input  wire siim_pkg::t_cell_st i_next,
    output siim_pkg::t_cell_st      o_st
);

    logic [31:0] r_s, n_s;
    logic [31:0] r_e, n_e;
    logic        r_b, n_b;
    logic        r_m, n_m;
    logic        w_before;

    assign w_before = $signed(r_e) < $signed(i_lo);

    always_comb begin
        n_s = r_s;
        n_e = r_e;
        n_b = r_b;
        n_m = r_m;
        case (i_op)
            siim_pkg::OP_HOLD: begin
            end
            siim_pkg::OP_CMP: begin
                n_b = i_valid & w_before;
                n_m = i_valid & !w_before & ($signed(r_s) <= $signed(i_hi));
            end
            siim_pkg::OP_LOAD: begin
                n_s = i_lo;
                n_e = i_hi;
                n_b = 1'b0;
                n_m = 1'b0;
            end
            siim_pkg::OP_PREV: begin
                n_s = i_prev.s;
                n_e = i_prev.e;
                n_b = i_prev.b;
                n_m = i_prev.m;
            end
            siim_pkg::OP_NEXT: begin
                n_s = i_next.s;
                n_e = i_next.e;
                n_b = i_next.b;
                n_m = i_next.m;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        r_e <= n_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= 1'b0;
            r_m <= 1'b0;
        end else begin
            r_b <= n_b;
            r_m <= n_m;
        end
    end

    assign o_st = '{s: r_s, e: r_e, b: r_b, m: r_m};

endmodule
`default_nettype wire

/* hw/rtl/sorted_interval_insert_merge.sv */
`default_nettype none
// ============================================================================
// sorted_interval_insert_merge
// Sorted table of disjoint closed intervals with insert and merge.
// ============================================================================
// The input channel takes one word per interval (start and end, either order).
// The output channel returns one word per input: the merged bounds, the slot
// where the merged interval sits, how many stored intervals it absorbed, the
// new fill count and an overflow flag for a refused insert into a full table.
// The table is a row of cells that all compare against the new interval at once
// and then shift one slot per cycle toward a neighbor.
// An item passes through the compare, update and shift states before its result
// is loaded into the output register; the shift state repeats for each further
// interval it absorbs, since the cell row closes the gap one slot per cycle.
// A new word is accepted in the cycle after the result is registered, even
// while that result is still stalled; a word is taken only after the last is done.
// Reset empties the table at once. While the receiver stalls, the finished
// result holds and the next item waits in its last cycle until the output
// register frees up.
// ============================================================================
module sorted_interval_insert_merge #(
    parameter int CAPACITY = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_new_start,
    input  wire logic signed [31:0] i_new_end,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_merged_start,
    output logic signed [31:0]      o_merged_end,
    output logic [3:0]              o_position,
    output logic [4:0]              o_removed_count,
    output logic [4:0]              o_new_count,
    output logic                    o_overflow
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    siim_pkg::t_state   r_state, n_state;
    logic [31:0]        r_lo, n_lo;
    logic [31:0]        r_hi, n_hi;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_removed, n_removed;
    logic [3:0]         r_pos, n_pos;
    logic               r_ovf, n_ovf;
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_out_s, r_out_e;
    logic [3:0]         r_out_pos;
    logic [4:0]         r_out_rm, r_out_cnt;
    logic               r_out_ovf;

    siim_pkg::t_cell_st w_st   [CAPACITY];
    siim_pkg::t_cell_st w_prev [CAPACITY];
    siim_pkg::t_cell_st w_next [CAPACITY];
    siim_pkg::t_cell_op w_op   [CAPACITY];
    logic [CAPACITY-1:0] w_b, w_m, w_head, w_last, w_region, w_valid;
    logic [31:0]        w_sel_s, w_sel_e, w_mlo, w_mhi, w_bc_lo, w_bc_hi;
    logic [3:0]         w_pos_enc;
    logic               w_any, w_full, w_pend, w_out_load;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign w_b[gi]     = w_st[gi].b;
            assign w_m[gi]     = w_st[gi].m;
            assign w_valid[gi] = r_count > CNT_W'(gi);
            assign w_region[gi] = !w_b[gi] & !w_head[gi];
            if (gi == 0) begin : g_first
                assign w_head[gi] = !w_b[gi];
                assign w_prev[gi] = w_st[gi];
            end else begin : g_mid
                assign w_head[gi] = !w_b[gi] & w_b[gi-1];
                assign w_prev[gi] = w_st[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_end
                assign w_last[gi] = w_m[gi];
                assign w_next[gi] = '{s: w_st[gi].s, e: w_st[gi].e, b: 1'b0, m: 1'b0};
            end else begin : g_body
                assign w_last[gi] = w_m[gi] & !w_m[gi+1];
                assign w_next[gi] = w_st[gi+1];
            end

            siim_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (w_op[gi]),
                .i_valid (w_valid[gi]),
                .i_lo    (w_bc_lo),
                .i_hi    (w_bc_hi),
                .i_prev  (w_prev[gi]),
                .i_next  (w_next[gi]),
                .o_st    (w_st[gi])
            );
        end
    endgenerate

    always_comb begin
        w_sel_s   = '0;
        w_sel_e   = '0;
        w_pos_enc = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_sel_s   = w_sel_s | ({32{w_head[i]}} & w_st[i].s);
            w_sel_e   = w_sel_e | ({32{w_last[i]}} & w_st[i].e);
            w_pos_enc = w_pos_enc | ({4{w_head[i]}} & 4'(i));
        end
    end

    assign w_any  = |w_m;
    assign w_pend = |w_m;
    assign w_full = r_count == CNT_W'(CAPACITY);
    assign w_mlo  = ($signed(w_sel_s) < $signed(r_lo)) ? w_sel_s : r_lo;
    assign w_mhi  = ($signed(w_sel_e) > $signed(r_hi)) ? w_sel_e : r_hi;
    assign w_bc_lo = (r_state == siim_pkg::ST_UPD && w_any) ? w_mlo : r_lo;
    assign w_bc_hi = (r_state == siim_pkg::ST_UPD && w_any) ? w_mhi : r_hi;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_op[i] = siim_pkg::OP_HOLD;
            case (r_state)
                siim_pkg::ST_CMP: begin
                    w_op[i] = siim_pkg::OP_CMP;
                end
                siim_pkg::ST_UPD: begin
                    if (w_any) begin
                        if (w_head[i]) begin
                            w_op[i] = siim_pkg::OP_LOAD;
                        end
                    end else if (!w_full) begin
                        if (w_head[i]) begin
                            w_op[i] = siim_pkg::OP_LOAD;
                        end else if (!w_b[i]) begin
                            w_op[i] = siim_pkg::OP_PREV;
                        end
                    end
                end
                siim_pkg::ST_SHIFT: begin
                    if (w_pend && w_region[i]) begin
                        w_op[i] = siim_pkg::OP_NEXT;
                    end
                end
                default: begin
                    w_op[i] = siim_pkg::OP_HOLD;
                end
            endcase
        end
    end

    always_comb begin
        n_state    = r_state;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_count    = r_count;
        n_removed  = r_removed;
        n_pos      = r_pos;
        n_ovf      = r_ovf;
        w_out_load = 1'b0;
        o_in_stall = r_state != siim_pkg::ST_IDLE;
        case (r_state)
            siim_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_new_start > i_new_end) begin
                        n_lo = i_new_end;
                        n_hi = i_new_start;
                    end else begin
                        n_lo = i_new_start;
                        n_hi = i_new_end;
                    end
                    n_state = siim_pkg::ST_CMP;
                end
            end
            siim_pkg::ST_CMP: begin
                n_state = siim_pkg::ST_UPD;
            end
            siim_pkg::ST_UPD: begin
                n_lo      = w_any ? w_mlo : r_lo;
                n_hi      = w_any ? w_mhi : r_hi;
                n_removed = w_any ? CNT_W'(1) : '0;
                n_ovf     = w_full & !w_any;
                n_pos     = (w_full & !w_any) ? 4'd0 : w_pos_enc;
                n_count   = (!w_any && !w_full) ? CNT_W'(r_count + 1'b1) : r_count;
                n_state   = siim_pkg::ST_SHIFT;
            end
            siim_pkg::ST_SHIFT: begin
                if (w_pend) begin
                    n_removed = CNT_W'(r_removed + 1'b1);
                    n_count   = CNT_W'(r_count - 1'b1);
                end else if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = siim_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = siim_pkg::ST_IDLE;
            end
        endcase
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= siim_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_removed <= n_removed;
        r_pos     <= n_pos;
        r_ovf     <= n_ovf;
        if (w_out_load) begin
            r_out_s   <= r_lo;
            r_out_e   <= r_hi;
            r_out_pos <= r_pos;
            r_out_rm  <= 5'(r_removed);
            r_out_cnt <= 5'(r_count);
            r_out_ovf <= r_ovf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_merged_start  = $signed(r_out_s);
    assign o_merged_end    = $signed(r_out_e);
    assign o_position      = r_out_pos;
    assign o_removed_count = r_out_rm;
    assign o_new_count     = r_out_cnt;
    assign o_overflow      = r_out_ovf;

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("Interval count exceeds the table capacity.");

    a_ovf_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> (o_removed_count == 5'd0
            && o_new_count == 5'(CAPACITY) && o_position == 4'd0))
        else $error("Refused insert reports a changed table.");

    a_ordered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_merged_start <= o_merged_end))
        else $error("Merged interval has its start above its end.");
`endif

endmodule
`default_nettype wire

/* bench/interval_table_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// interval_table_checker
// Watches both channels of the sorted interval table. It keeps its own copy of
// the table, predicts the merge that each accepted insert word causes, and
// compares every result word field by field with the oldest prediction.
// ============================================================================
module interval_table_checker #(
    parameter int DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic signed [31:0] i_new_start,
    input  wire logic signed [31:0] i_new_end,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic signed [31:0] i_merged_start,
    input  wire logic signed [31:0] i_merged_end,
    input  wire logic [3:0]         i_position,
    input  wire logic [4:0]         i_removed_count,
    input  wire logic [4:0]         i_new_count,
    input  wire logic               i_overflow,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_refusals,
    output int                      o_multi_merges,
    output int                      o_deepest_merge
);

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [3:0]  slot;
        logic [4:0]  absorbed;
        logic [4:0]  fill;
        logic        refused;
    } t_merge_word;

    logic signed [31:0] span_lo [DEPTH];
    logic signed [31:0] span_hi [DEPTH];
    int                 held = 0;
    t_merge_word        pending_merges [$];
    int                 mismatches = 0;
    int                 refusals = 0;
    int                 multi_merges = 0;
    int                 deepest = 0;

    task automatic predict_merge(input logic signed [31:0] a, input logic signed [31:0] b,
                                 output t_merge_word w);
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        int                 n;
        int                 stop;
        int                 first;
        int                 removed;
        int                 idx;
        bit                 hit;
        lo = a;
        hi = b;
        if (lo > hi) begin
            lo = b;
            hi = a;
        end
        n = held;
        hit = 1'b0;
        first = 0;
        removed = 0;
        w.refused = 1'b0;
        for (stop = 0; stop < n; stop++) begin
            if (hi < span_lo[stop]) break;
            if (lo <= span_hi[stop]) begin
                if (!hit) begin
                    hit = 1'b1;
                    first = stop;
                end
                if (span_lo[stop] < lo) lo = span_lo[stop];
                if (span_hi[stop] > hi) hi = span_hi[stop];
            end
        end
        if (!hit) begin
            if (n >= DEPTH) begin
                w.refused = 1'b1;
                first = 0;
            end else begin
                for (idx = n; idx > stop; idx--) begin
                    span_lo[idx] = span_lo[idx - 1];
                    span_hi[idx] = span_hi[idx - 1];
                end
                span_lo[stop] = lo;
                span_hi[stop] = hi;
                first = stop;
                n = n + 1;
            end
        end else begin
            removed = stop - first;
            span_lo[first] = lo;
            span_hi[first] = hi;
            for (idx = stop; idx < n; idx++) begin
                span_lo[first + 1 + idx - stop] = span_lo[idx];
                span_hi[first + 1 + idx - stop] = span_hi[idx];
            end
            n = n - removed + 1;
        end
        held = n;
        w.lo = lo;
        w.hi = hi;
        w.slot = 4'(first);
        w.absorbed = 5'(removed);
        w.fill = 5'(n);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_merge_word want;
        if (!i_rst_n) begin
            held = 0;
            pending_merges.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_merges.size() == 0) begin
                    $error("Result word with no insert outstanding: start %0d, end %0d",
                           i_merged_start, i_merged_end);
                    mismatches++;
                end else begin
                    want = pending_merges.pop_front();
                    check_field("merged_start", $signed(want.lo), i_merged_start);
                    check_field("merged_end", $signed(want.hi), i_merged_end);
                    check_field("position", want.slot, i_position);
                    check_field("removed_count", want.absorbed, i_removed_count);
                    check_field("new_count", want.fill, i_new_count);
                    check_field("overflow", want.refused, i_overflow);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_merge(i_new_start, i_new_end, want);
                if (want.refused) refusals++;
                if (want.absorbed > 1) multi_merges++;
                if (want.absorbed > deepest) deepest = want.absorbed;
                pending_merges.push_back(want);
            end
        end
        o_errors <= mismatches;
        o_pending <= pending_merges.size();
        o_refusals <= refusals;
        o_multi_merges <= multi_merges;
        o_deepest_merge <= deepest;
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Drives insert words into the sorted interval table: a directed sequence of
// merges, touching and adjacent bounds, reversed bounds and a full table,
// then random episodes that cluster inserts in fresh regions of the number
// line under four mixes of sender gaps and receiver stalls.
// ============================================================================
module tb_top;

    localparam int                 TABLE_DEPTH = 16;
    localparam int                 PHASE_WORDS = 388;
    localparam int                 CYCLE_LIMIT = 600000;
    localparam int                 DRAIN_CYCLES = 30;
    localparam logic signed [31:0] BOUND_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] BOUND_MAX = 32'sh7FFF_FFFF;
    localparam longint             CURSOR_CEILING = 64'sd2080000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] new_start = '0;
    logic signed [31:0] new_end = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] merged_start;
    logic signed [31:0] merged_end;
    logic [3:0]         position;
    logic [4:0]         removed_count;
    logic [4:0]         new_count;
    logic               overflow;

    int                 errors;
    int                 pending;
    int                 refusals;
    int                 multi_merges;
    int                 deepest_merge;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 words_sent = 0;
    int                 cycle_count = 0;
    longint             cursor = 1024;

    sorted_interval_insert_merge #(
        .CAPACITY(TABLE_DEPTH)
    ) u_top (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_new_start(new_start),
        .i_new_end(new_end),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_merged_start(merged_start),
        .o_merged_end(merged_end),
        .o_position(position),
        .o_removed_count(removed_count),
        .o_new_count(new_count),
        .o_overflow(overflow)
    );

    interval_table_checker #(
        .DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .i_in_stall(in_stall),
        .i_new_start(new_start),
        .i_new_end(new_end),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_merged_start(merged_start),
        .i_merged_end(merged_end),
        .i_position(position),
        .i_removed_count(removed_count),
        .i_new_count(new_count),
        .i_overflow(overflow),
        .o_errors(errors),
        .o_pending(pending),
        .o_refusals(refusals),
        .o_multi_merges(multi_merges),
        .o_deepest_merge(deepest_merge)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_word(input logic signed [31:0] first_bound,
                             input logic signed [31:0] second_bound);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        new_start <= first_bound;
        new_end <= second_bound;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_span(input longint lo, input longint hi);
        if ($urandom_range(4) == 0) begin
            send_word(32'(hi), 32'(lo));
        end else begin
            send_word(32'(lo), 32'(hi));
        end
    endtask

    // Each episode works in a fresh region above the last one, so the covered
    // part of the number line grows slowly and the table keeps changing shape.
    task automatic run_phase(input int quota);
        int     phase_start;
        int     body;
        int     k;
        int     pick;
        longint origin;
        longint s;
        longint e;
        phase_start = words_sent;
        while (words_sent - phase_start < quota) begin
            if (cursor < CURSOR_CEILING) begin
                cursor += $urandom_range(5 << 22, 1 << 24);
            end
            origin = cursor + ($urandom & 32'h000F_FC00);
            if ($urandom_range(3) == 0) begin
                send_span(longint'(BOUND_MIN), cursor - 1);
            end
            body = $urandom_range(14, 22);
            for (k = 0; k < body; k++) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    s = origin + $urandom_range(400);
                    e = s + $urandom_range(6);
                end else if (pick < 75) begin
                    s = origin + 5 * $urandom_range(80);
                    e = s + ($urandom_range(1) ? 5 : 4);
                end else if (pick < 90) begin
                    s = origin + $urandom_range(400);
                    e = s + $urandom_range(200, 20);
                end else if (pick < 96) begin
                    s = $signed($urandom);
                    e = s + $urandom_range(3);
                    if (e > longint'(BOUND_MAX)) e = s;
                end else begin
                    s = origin;
                    e = origin + 600;
                end
                send_span(s, e);
            end
            if ($urandom_range(9) < 7) begin
                send_span(origin, origin + 600);
            end
        end
    endtask

    initial begin
        int k;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_word(5, 10);
        send_word(20, 30);
        send_word(12, 14);
        send_word(10, 12);
        send_word(15, 16);
        send_word(40, 35);
        send_word(BOUND_MIN, BOUND_MIN);
        send_word(BOUND_MAX, BOUND_MAX);
        for (k = 0; k < 10; k++) begin
            send_word(100 + 10 * k, 102 + 10 * k);
        end
        send_word(500, 600);
        send_word(4, 1);
        send_word(14, 15);
        send_word(BOUND_MIN, 1000);

        idle_pct = 0;
        stall_pct = 0;
        run_phase(PHASE_WORDS);
        idle_pct = 83;
        stall_pct = 0;
        run_phase(PHASE_WORDS);
        idle_pct = 0;
        stall_pct = 83;
        run_phase(PHASE_WORDS);
        idle_pct = 32;
        stall_pct = 32;
        run_phase(PHASE_WORDS);

        send_word(BOUND_MIN, BOUND_MAX);
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Inserted %0d intervals under four mixes of sender gaps and receiver stalls.",
                 words_sent);
        $display("%0d inserts absorbed two or more entries (up to %0d at once); %0d refused.",
                 multi_merges, deepest_merge, refusals);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
